### design/pa_pkg.sv
// Package: shared types, codes and constants for primitive assembly.
`timescale 1ns / 1ps
package pa_pkg;

  localparam int REF_WIDTH = 32;
  localparam int FIELD_REF_WIDTH = 32;
  localparam int REF_KEEP = (REF_WIDTH < FIELD_REF_WIDTH) ? REF_WIDTH : FIELD_REF_WIDTH;

  localparam logic [1:0] MODE_BEGIN  = 2'd0;
  localparam logic [1:0] MODE_VERTEX = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;

  localparam logic [2:0] TYPE_NONE       = 3'd0;
  localparam logic [2:0] TYPE_POINTS     = 3'd1;
  localparam logic [2:0] TYPE_LINES      = 3'd2;
  localparam logic [2:0] TYPE_LINE_STRIP = 3'd3;
  localparam logic [2:0] TYPE_TRIANGLES  = 3'd4;
  localparam logic [2:0] TYPE_TRI_STRIP  = 3'd5;
  localparam logic [2:0] TYPE_TRI_FAN    = 3'd6;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_TRI   = 2'd2;

  typedef logic [REF_KEEP-1:0] ref_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [2:0]                 prim_type;
    logic [FIELD_REF_WIDTH-1:0] vertex_ref;
  } item_t;

  typedef struct packed {
    logic [FIELD_REF_WIDTH-1:0] out_vertex_ref;
    logic [1:0]                 prim_kind;
    logic [1:0]                 corner;
    logic                       last_corner;
  } result_t;

  // One assembled primitive, corners in emission order.
  typedef struct packed {
    logic [1:0] kind;
    ref_t       ref_a;
    ref_t       ref_b;
    ref_t       ref_c;
  } prim_t;

  // Index of the final corner for a primitive kind.
  function automatic logic [1:0] last_index(input logic [1:0] kind);
    logic [1:0] idx;
    idx = 2'd0;
    case (kind)
      KIND_LINE: idx = 2'd1;
      KIND_TRI:  idx = 2'd2;
      default:   idx = 2'd0;
    endcase
    return idx;
  endfunction

endpackage

### design/primitive_assembly.sv
// Top level: batch state tracking and primitive assembly into corner transfers.
//
//   channel  | signals                            | direction
//   item     | item_valid, item_stall, item       | in  (begin / vertex / end)
//   result   | result_valid, result_stall, result | out (one corner per transfer)
//
// A vertex updates the batch state at its transfer; a completed primitive loads
// the corner buffer, which emits 1, 2 or 3 corners, one per cycle unless result_stall
// holds it. A vertex that completes a primitive stalls while the buffer is occupied, so
// the single result port sets the sustained rate. Items that complete no primitive
// transfer every cycle, even while corners drain. Reset (rst, synchronous) clears
// the batch type, the vertex count, the held vertices and the corner buffer.
`timescale 1ns / 1ps
module primitive_assembly (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  pa_pkg::item_t   item,
  output logic            result_valid,
  input  logic            result_stall,
  output pa_pkg::result_t result
);

  logic [2:0]    batch_type;
  logic [1:0]    seen_count;
  pa_pkg::ref_t  first_ref;
  pa_pkg::ref_t  older_ref;
  pa_pkg::ref_t  newer_ref;

  logic [2:0]    batch_type_next;
  logic [1:0]    seen_count_next;
  pa_pkg::ref_t  first_ref_next;
  pa_pkg::ref_t  older_ref_next;
  pa_pkg::ref_t  newer_ref_next;

  pa_pkg::ref_t  v;
  logic          emit;
  pa_pkg::prim_t prim;
  logic          buf_free;
  logic          accept;
  logic          load;

  assign v = item.vertex_ref[pa_pkg::REF_KEEP-1:0];

  always_comb begin
    batch_type_next = batch_type;
    seen_count_next = seen_count;
    first_ref_next  = first_ref;
    older_ref_next  = older_ref;
    newer_ref_next  = newer_ref;
    emit            = 1'b0;
    prim.kind       = pa_pkg::KIND_POINT;
    prim.ref_a      = v;
    prim.ref_b      = v;
    prim.ref_c      = v;
    if (item.mode == pa_pkg::MODE_BEGIN) begin
      batch_type_next = item.prim_type;
      seen_count_next = 2'd0;
    end else if (item.mode == pa_pkg::MODE_END) begin
      batch_type_next = pa_pkg::TYPE_NONE;
      seen_count_next = 2'd0;
    end else if (item.mode == pa_pkg::MODE_VERTEX) begin
      case (batch_type) inside
        pa_pkg::TYPE_POINTS: begin
          emit = 1'b1;
        end
        pa_pkg::TYPE_LINES: begin
          if (seen_count == 2'd0) begin
            older_ref_next  = v;
            seen_count_next = 2'd1;
          end else begin
            emit            = 1'b1;
            prim.kind       = pa_pkg::KIND_LINE;
            prim.ref_a      = older_ref;
            seen_count_next = 2'd0;
          end
        end
        pa_pkg::TYPE_LINE_STRIP: begin
          emit            = (seen_count != 2'd0);
          prim.kind       = pa_pkg::KIND_LINE;
          prim.ref_a      = newer_ref;
          newer_ref_next  = v;
          seen_count_next = 2'd1;
        end
        pa_pkg::TYPE_TRIANGLES, pa_pkg::TYPE_TRI_STRIP, pa_pkg::TYPE_TRI_FAN: begin
          prim.kind  = pa_pkg::KIND_TRI;
          prim.ref_a = (batch_type == pa_pkg::TYPE_TRI_FAN) ? first_ref : older_ref;
          prim.ref_b = newer_ref;
          if (seen_count == 2'd0) begin
            if (batch_type == pa_pkg::TYPE_TRI_FAN) begin
              first_ref_next = v;
            end else begin
              older_ref_next = v;
            end
            seen_count_next = 2'd1;
          end else if (seen_count == 2'd1) begin
            newer_ref_next  = v;
            seen_count_next = 2'd2;
          end else begin
            emit = 1'b1;
            if (batch_type == pa_pkg::TYPE_TRIANGLES) begin
              seen_count_next = 2'd0;
            end else begin
              // Slide the window; a fan keeps its first vertex.
              if (batch_type == pa_pkg::TYPE_TRI_STRIP) begin
                older_ref_next = newer_ref;
              end
              newer_ref_next = v;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold only items that complete a primitive while the buffer is occupied.
  assign item_stall = emit && !buf_free;
  assign accept     = item_valid && !item_stall;
  assign load       = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_type <= pa_pkg::TYPE_NONE;
      seen_count <= 2'd0;
    end else if (accept) begin
      batch_type <= batch_type_next;
      seen_count <= seen_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_ref <= '0;
      older_ref <= '0;
      newer_ref <= '0;
    end else if (accept) begin
      first_ref <= first_ref_next;
      older_ref <= older_ref_next;
      newer_ref <= newer_ref_next;
    end
  end

  pa_corner_buf u_corner_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .prim         (prim),
    .free         (buf_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_seen_range: assert property (@(posedge clk) disable iff (rst) seen_count != 2'd3)
    else $error("vertex count out of range");
  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    batch_type == pa_pkg::TYPE_NONE || batch_type == pa_pkg::TYPE_POINTS
    |-> seen_count == 2'd0)
    else $error("vertices held without an assembling type");
  a_begin_clear: assert property (@(posedge clk) disable iff (rst)
    accept && (item.mode == pa_pkg::MODE_BEGIN || item.mode == pa_pkg::MODE_END)
    |=> seen_count == 2'd0)
    else $error("held vertices survived a batch boundary");
  a_load_valid: assert property (@(posedge clk) disable iff (rst) load |=> result_valid)
    else $error("assembled primitive produced no corner");

endmodule

### design/pa_corner_buf.sv
// Corner serializer: holds one primitive and emits its corners one transfer at a time.
`timescale 1ns / 1ps
module pa_corner_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  pa_pkg::prim_t   prim,
  output logic            free,
  output logic            result_valid,
  input  logic            result_stall,
  output pa_pkg::result_t result
);

  logic          busy;
  logic [1:0]    idx;
  pa_pkg::prim_t prim_q;
  logic          last;
  pa_pkg::ref_t  sel_ref;

  assign last = (idx == pa_pkg::last_index(prim_q.kind));
  // Room for a new primitive once the final corner leaves this cycle.
  assign free = !busy || (!result_stall && last);

  always_comb begin
    case (idx)
      2'd0:    sel_ref = prim_q.ref_a;
      2'd1:    sel_ref = prim_q.ref_b;
      default: sel_ref = prim_q.ref_c;
    endcase
  end

  assign result_valid          = busy;
  assign result.out_vertex_ref = pa_pkg::FIELD_REF_WIDTH'(sel_ref);
  assign result.prim_kind      = prim_q.kind;
  assign result.corner         = idx;
  assign result.last_corner    = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && !result_stall) begin
      if (last) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prim_q <= prim;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst) load |-> free)
    else $error("primitive loaded while corners still pending");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= pa_pkg::last_index(prim_q.kind))
    else $error("corner index past end of primitive");
  a_idle_idx: assert property (@(posedge clk) disable iff (rst) !busy |-> idx == 2'd0)
    else $error("corner index not rewound while idle");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    busy && last && !result_stall && !load |=> !busy)
    else $error("buffer did not drain after final corner");

endmodule
